>>> rtl/crsi_pkg.sv
// Shared types and fixed constants for the Catmull-Rom stroke interpolator.
// Used by crsi_front, crsi_back and the top level; no dependencies.
package crsi_pkg;

  localparam int ATTR_W    = 16;            // pressure, tilts, wheel, velocity, direction
  localparam int PT_ATTR_W = 6 * ATTR_W;    // attribute bits of one control point
  localparam int T_W       = 17;            // segment parameter, 65536 = 1.0
  localparam logic [T_W-1:0] T_ONE = 17'h10000;
  localparam int WGT_W     = 32;            // Q30 blend weights
  localparam int EW        = 54;            // weight polynomial width
  localparam int ACC_W     = 64;
  localparam int FRAC_W    = 30;
  localparam int DIV_W     = 17;            // divider numerator width
  localparam logic [15:0] PREC_RESET = 16'd256;
  localparam logic [15:0] DIR_HALF   = 16'h8000;

  localparam logic [2:0] FLD_X    = 3'd0;
  localparam logic [2:0] FLD_Y    = 3'd1;
  localparam logic [2:0] FLD_PRES = 3'd2;
  localparam logic [2:0] FLD_XT   = 3'd3;
  localparam logic [2:0] FLD_YT   = 3'd4;
  localparam logic [2:0] FLD_WH   = 3'd5;
  localparam logic [2:0] FLD_VEL  = 3'd6;
  localparam logic [1:0] TAP_LAST = 2'd3;

  typedef enum logic [2:0] {
    F_IDLE, F_CHK, F_SQX, F_SQY, F_SRCH, F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_DIVT, B_DIVD, B_STEP, B_T2, B_T3, B_WGT, B_MAC, B_OUT
  } back_state_t;

endpackage

>>> rtl/crsi_front.sv
// Front end: control point window, step precision register and step count search.
// Pushes one segment job per qualifying point; uses crsi_pkg.
module crsi_front #(
  parameter int MAX_POINTS  = 64,
  parameter int COORD_WIDTH = 24,
  parameter int PW   = 2 * COORD_WIDTH + crsi_pkg::PT_ATTR_W,
  parameter int CNTW = $clog2(MAX_POINTS + 1),
  parameter int JW   = 4 * PW + CNTW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [PW-1:0] in_point,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [15:0]   cfg_data,
  output logic          job_valid,
  input  logic          job_ready,
  output logic [JW-1:0] job_data
);

  localparam int LW   = 16 + CNTW;
  localparam int DXW  = COORD_WIDTH + 1;
  localparam int CMPW = (DXW > LW) ? DXW : LW;

  crsi_pkg::front_state_t state_r, state_nxt;

  logic [PW-1:0]     win_r [4];
  logic [2:0]        held_r;
  logic [15:0]       prec_r;
  logic [CNTW-1:0]   cnt_r;
  logic [LW-1:0]     cm_r;
  logic [2*LW-1:0]   sqx_r;
  logic [2*LW:0]     s_r;

  logic [15:0]          prec;
  logic [LW-1:0]        lim;
  logic signed [DXW-1:0] dx, dy;
  logic [DXW-1:0]       adx, ady;
  logic [LW-1:0]        adx_t, ady_t;
  logic                 big;
  logic [2*LW-1:0]      sq;
  logic                 stop;
  logic                 in_acc;

  assign prec  = (prec_r == 16'd0) ? 16'd1 : prec_r;
  assign lim   = LW'(MAX_POINTS) * LW'(prec);
  assign dx    = DXW'($signed(win_r[2][COORD_WIDTH-1:0]))
               - DXW'($signed(win_r[1][COORD_WIDTH-1:0]));
  assign dy    = DXW'($signed(win_r[2][2*COORD_WIDTH-1:COORD_WIDTH]))
               - DXW'($signed(win_r[1][2*COORD_WIDTH-1:COORD_WIDTH]));
  assign adx   = dx[DXW-1] ? DXW'(-dx) : DXW'(dx);
  assign ady   = dy[DXW-1] ? DXW'(-dy) : DXW'(dy);
  assign adx_t = LW'(adx);
  assign ady_t = LW'(ady);
  assign big   = (CMPW'(adx) >= CMPW'(lim)) || (CMPW'(ady) >= CMPW'(lim));
  assign sq    = cm_r * cm_r;
  assign stop  = (cnt_r == CNTW'(MAX_POINTS)) || ((2*LW+1)'(sq) > s_r);

  assign in_ready  = (state_r == crsi_pkg::F_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign job_valid = (state_r == crsi_pkg::F_PUSH);
  assign job_data  = {cnt_r, win_r[3], win_r[2], win_r[1], win_r[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crsi_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      crsi_pkg::F_IDLE: begin
        if (in_acc && held_r >= 3'd3) state_nxt = crsi_pkg::F_CHK;
      end
      crsi_pkg::F_CHK:  state_nxt = big ? crsi_pkg::F_PUSH : crsi_pkg::F_SQX;
      crsi_pkg::F_SQX:  state_nxt = crsi_pkg::F_SQY;
      crsi_pkg::F_SQY:  state_nxt = crsi_pkg::F_SRCH;
      crsi_pkg::F_SRCH: begin
        if (stop) state_nxt = (cnt_r == '0) ? crsi_pkg::F_IDLE : crsi_pkg::F_PUSH;
      end
      crsi_pkg::F_PUSH: begin
        if (job_ready) state_nxt = crsi_pkg::F_IDLE;
      end
      default: state_nxt = crsi_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 3'd0;
      prec_r <= crsi_pkg::PREC_RESET;
    end else begin
      if (cfg_valid) prec_r <= cfg_data;
      if (in_acc && held_r != 3'd4) held_r <= held_r + 3'd1;
    end
  end

  // window: entry 0 is the oldest point
  always_ff @(posedge clk) begin
    if (in_acc) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= win_r[3];
      win_r[3] <= in_point;
    end
    unique case (state_r)
      crsi_pkg::F_CHK: begin
        cnt_r <= big ? CNTW'(MAX_POINTS) : '0;
        cm_r  <= LW'(prec);
      end
      crsi_pkg::F_SQX: sqx_r <= adx_t * adx_t;
      crsi_pkg::F_SQY: s_r <= (2*LW+1)'(sqx_r) + (2*LW+1)'(ady_t * ady_t);
      crsi_pkg::F_SRCH: begin
        if (!stop) begin
          cnt_r <= cnt_r + CNTW'(1);
          cm_r  <= cm_r + LW'(prec);
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/crsi_fifo.sv
// Two-entry job queue between the front end and the interpolation back end.
// Self-contained; no package use.
module crsi_fifo #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [DW-1:0] in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [DW-1:0] out_data
);

  logic [DW-1:0] mem_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          push, pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/crsi_back.sv
// Back end: per-segment reciprocal setup, weight evaluation and a shared
// multiply-accumulate over seven fields and four taps per point; uses crsi_pkg.
module crsi_back #(
  parameter int MAX_POINTS  = 64,
  parameter int COORD_WIDTH = 24,
  parameter int PW   = 2 * COORD_WIDTH + crsi_pkg::PT_ATTR_W,
  parameter int CNTW = $clog2(MAX_POINTS + 1),
  parameter int JW   = 4 * PW + CNTW,
  parameter int ODW  = 2 * COORD_WIDTH + 5 * crsi_pkg::ATTR_W + 16 + crsi_pkg::T_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  output logic           job_ready,
  input  logic [JW-1:0]  job_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [ODW-1:0] out_data,
  output logic           out_last
);

  localparam int VW = (COORD_WIDTH > 17) ? COORD_WIDTH : 17;
  localparam int AB = 2 * COORD_WIDTH;
  localparam int TW = crsi_pkg::T_W;
  localparam int EW = crsi_pkg::EW;
  localparam logic signed [EW-1:0] W_ONE = EW'(1) <<< 49;
  localparam logic signed [EW-1:0] W_RND = EW'(1) <<< 18;
  localparam logic signed [crsi_pkg::ACC_W-1:0] A_RND = crsi_pkg::ACC_W'(1) <<< 29;

  crsi_pkg::back_state_t state_r, state_nxt;

  logic [JW-1:0]     job_r;
  logic [CNTW-1:0]   cnt;
  logic [CNTW-1:0]   n_r;
  logic [4:0]        dv_cnt_r;
  logic [crsi_pkg::DIV_W-1:0] dv_num_r, dv_num_nxt;
  logic [CNTW:0]     dv_rem_r, dv_rem_nxt, rem_sh;
  logic              dv_ge, dv_done, neg_r;
  logic [TW-1:0]     qt_r, t_r;
  logic [CNTW-1:0]   rt_r, rr_r, dr_r, drr_r;
  logic signed [TW-1:0] dq_r, d_r;
  logic [33:0]       tt_r;
  logic [49:0]       t3_r;
  logic signed [crsi_pkg::WGT_W-1:0] w_r [4];
  logic [2:0]        fld_r, acc_fld_r;
  logic [1:0]        tap_r, acc_tap_r;
  logic              issue_done_r, pv_r;
  logic signed [crsi_pkg::WGT_W+VW-1:0] prod_r;
  logic signed [crsi_pkg::ACC_W-1:0]    acc_r, sum, rsh;

  logic [COORD_WIDTH-1:0] x_res_r, y_res_r;
  logic [15:0] pres_res_r, xt_res_r, yt_res_r, wh_res_r, vel_res_r;

  logic [15:0]        dir_b, dir_c;
  logic signed [17:0] d0, dwrap;
  logic [CNTW:0]      rsum, dsum;
  logic signed [EW-1:0] t1s, t2s, t3s;
  logic signed [VW-1:0] v_sel;
  logic               mac_end;

  function automatic logic signed [VW-1:0] fval(input logic [PW-1:0] p, input logic [2:0] f);
    logic signed [VW-1:0] v;
    v = '0;
    unique case (f)
      crsi_pkg::FLD_X:    v = VW'($signed(p[COORD_WIDTH-1:0]));
      crsi_pkg::FLD_Y:    v = VW'($signed(p[AB-1:COORD_WIDTH]));
      crsi_pkg::FLD_PRES: v = VW'($signed({1'b0, p[AB+15:AB]}));
      crsi_pkg::FLD_XT:   v = VW'($signed(p[AB+31:AB+16]));
      crsi_pkg::FLD_YT:   v = VW'($signed(p[AB+47:AB+32]));
      crsi_pkg::FLD_WH:   v = VW'($signed(p[AB+63:AB+48]));
      crsi_pkg::FLD_VEL:  v = VW'($signed({1'b0, p[AB+79:AB+64]}));
      default:            v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [crsi_pkg::ACC_W-1:0] clampv(
      input logic signed [crsi_pkg::ACC_W-1:0] v,
      input logic signed [crsi_pkg::ACC_W-1:0] lo,
      input logic signed [crsi_pkg::ACC_W-1:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  assign cnt   = job_r[JW-1 -: CNTW];
  assign dir_b = job_r[PW + AB + 95 -: 16];
  assign dir_c = job_r[2*PW + AB + 95 -: 16];
  assign d0    = $signed({2'b00, dir_c}) - $signed({2'b00, dir_b});
  // take the shorter way round the turn
  assign dwrap = (d0 <= -18'sd32768) ? d0 + 18'sd65536 :
                 (d0 >= 18'sd32768)  ? d0 - 18'sd65536 : d0;

  // restoring divider, one quotient bit per cycle
  assign rem_sh     = {dv_rem_r[CNTW-1:0], dv_num_r[crsi_pkg::DIV_W-1]};
  assign dv_ge      = rem_sh >= {1'b0, cnt};
  assign dv_rem_nxt = dv_ge ? rem_sh - {1'b0, cnt} : rem_sh;
  assign dv_num_nxt = {dv_num_r[crsi_pkg::DIV_W-2:0], dv_ge};
  assign dv_done    = (dv_cnt_r == 5'(crsi_pkg::DIV_W - 1));

  assign rsum = {1'b0, rr_r} + {1'b0, rt_r};
  assign dsum = {1'b0, drr_r} + {1'b0, dr_r};

  assign t1s = $signed(EW'(t_r)) <<< 32;
  assign t2s = $signed(EW'(tt_r)) <<< 16;
  assign t3s = $signed(EW'(t3_r));

  assign v_sel   = fval(job_r[tap_r*PW +: PW], fld_r);
  assign sum     = acc_r + crsi_pkg::ACC_W'(prod_r);
  assign rsh     = (sum + A_RND) >>> crsi_pkg::FRAC_W;
  assign mac_end = pv_r && (acc_tap_r == crsi_pkg::TAP_LAST)
                   && (acc_fld_r == crsi_pkg::FLD_VEL);

  assign job_ready = (state_r == crsi_pkg::B_IDLE);
  assign out_valid = (state_r == crsi_pkg::B_OUT);
  assign out_last  = (n_r == cnt);
  assign out_data  = {t_r, dir_b + d_r[15:0], vel_res_r, wh_res_r, yt_res_r, xt_res_r,
                      pres_res_r, y_res_r, x_res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crsi_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      crsi_pkg::B_IDLE: if (job_valid) state_nxt = crsi_pkg::B_DIVT;
      crsi_pkg::B_DIVT: if (dv_done) state_nxt = crsi_pkg::B_DIVD;
      crsi_pkg::B_DIVD: if (dv_done) state_nxt = crsi_pkg::B_STEP;
      crsi_pkg::B_STEP: state_nxt = crsi_pkg::B_T2;
      crsi_pkg::B_T2:   state_nxt = crsi_pkg::B_T3;
      crsi_pkg::B_T3:   state_nxt = crsi_pkg::B_WGT;
      crsi_pkg::B_WGT:  state_nxt = crsi_pkg::B_MAC;
      crsi_pkg::B_MAC:  if (mac_end) state_nxt = crsi_pkg::B_OUT;
      crsi_pkg::B_OUT: begin
        if (out_ready) state_nxt = (n_r == cnt) ? crsi_pkg::B_IDLE : crsi_pkg::B_STEP;
      end
      default: state_nxt = crsi_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
    end else begin
      if (state_r == crsi_pkg::B_IDLE) n_r <= '0;
      else if (state_r == crsi_pkg::B_STEP) n_r <= n_r + CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      crsi_pkg::B_IDLE: begin
        if (job_valid) job_r <= job_data;
        dv_num_r <= crsi_pkg::T_ONE;
        dv_rem_r <= '0;
        dv_cnt_r <= '0;
      end
      crsi_pkg::B_DIVT: begin
        dv_cnt_r <= dv_cnt_r + 5'd1;
        if (dv_done) begin
          qt_r     <= dv_num_nxt;
          rt_r     <= dv_rem_nxt[CNTW-1:0];
          neg_r    <= dwrap[17];
          dv_num_r <= dwrap[17] ? crsi_pkg::DIV_W'(-dwrap) : crsi_pkg::DIV_W'(dwrap);
          dv_rem_r <= '0;
          dv_cnt_r <= '0;
        end else begin
          dv_num_r <= dv_num_nxt;
          dv_rem_r <= dv_rem_nxt;
        end
      end
      crsi_pkg::B_DIVD: begin
        dv_cnt_r <= dv_cnt_r + 5'd1;
        dv_num_r <= dv_num_nxt;
        dv_rem_r <= dv_rem_nxt;
        if (dv_done) begin
          // floor division of a negative delta
          if (neg_r && dv_rem_nxt != '0) begin
            dq_r <= -$signed(dv_num_nxt + TW'(1));
            dr_r <= cnt - dv_rem_nxt[CNTW-1:0];
          end else begin
            dq_r <= neg_r ? -$signed(dv_num_nxt) : $signed(dv_num_nxt);
            dr_r <= dv_rem_nxt[CNTW-1:0];
          end
          t_r   <= '0;
          rr_r  <= '0;
          d_r   <= '0;
          drr_r <= '0;
        end
      end
      crsi_pkg::B_STEP: begin
        if (rsum >= {1'b0, cnt}) begin
          rr_r <= CNTW'(rsum - {1'b0, cnt});
          t_r  <= t_r + qt_r + TW'(1);
        end else begin
          rr_r <= CNTW'(rsum);
          t_r  <= t_r + qt_r;
        end
        if (dsum >= {1'b0, cnt}) begin
          drr_r <= CNTW'(dsum - {1'b0, cnt});
          d_r   <= d_r + dq_r + TW'(1);
        end else begin
          drr_r <= CNTW'(dsum);
          d_r   <= d_r + dq_r;
        end
      end
      crsi_pkg::B_T2: tt_r <= 34'(t_r * t_r);
      crsi_pkg::B_T3: t3_r <= 50'(tt_r[32:0] * t_r);
      crsi_pkg::B_WGT: begin
        w_r[0] <= crsi_pkg::WGT_W'((-t3s + (t2s <<< 1) - t1s + W_RND) >>> 19);
        w_r[1] <= crsi_pkg::WGT_W'((t3s * 3 - t2s * 5 + W_ONE + W_RND) >>> 19);
        w_r[2] <= crsi_pkg::WGT_W'((t2s * 4 - t3s * 3 + t1s + W_RND) >>> 19);
        w_r[3] <= crsi_pkg::WGT_W'((t3s - t2s + W_RND) >>> 19);
        fld_r        <= crsi_pkg::FLD_X;
        tap_r        <= '0;
        issue_done_r <= 1'b0;
        pv_r         <= 1'b0;
        acc_r        <= '0;
      end
      crsi_pkg::B_MAC: begin
        // issue stage: one product per beat
        pv_r <= !issue_done_r;
        if (!issue_done_r) begin
          prod_r    <= w_r[tap_r] * v_sel;
          acc_fld_r <= fld_r;
          acc_tap_r <= tap_r;
          tap_r     <= tap_r + 2'd1;
          if (tap_r == crsi_pkg::TAP_LAST) begin
            if (fld_r == crsi_pkg::FLD_VEL) issue_done_r <= 1'b1;
            else fld_r <= fld_r + 3'd1;
          end
        end
        // accumulate stage
        if (pv_r) begin
          if (acc_tap_r == crsi_pkg::TAP_LAST) begin
            acc_r <= '0;
            unique case (acc_fld_r)
              crsi_pkg::FLD_X: x_res_r <= COORD_WIDTH'(clampv(rsh,
                  -(crsi_pkg::ACC_W'(1) <<< (COORD_WIDTH - 1)),
                  (crsi_pkg::ACC_W'(1) <<< (COORD_WIDTH - 1)) - 1));
              crsi_pkg::FLD_Y: y_res_r <= COORD_WIDTH'(clampv(rsh,
                  -(crsi_pkg::ACC_W'(1) <<< (COORD_WIDTH - 1)),
                  (crsi_pkg::ACC_W'(1) <<< (COORD_WIDTH - 1)) - 1));
              crsi_pkg::FLD_PRES: pres_res_r <= 16'(clampv(rsh, 0, 32768));
              crsi_pkg::FLD_XT:   xt_res_r   <= 16'(clampv(rsh, -32768, 32767));
              crsi_pkg::FLD_YT:   yt_res_r   <= 16'(clampv(rsh, -32768, 32767));
              crsi_pkg::FLD_WH:   wh_res_r   <= 16'(clampv(rsh, -32768, 32767));
              crsi_pkg::FLD_VEL:  vel_res_r  <= 16'(clampv(rsh, 0, 32768));
              default: ;
            endcase
          end else begin
            acc_r <= sum;
          end
        end
      end
      default: ;
    endcase
  end

  a_out_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (n_r != '0) && (n_r <= cnt))
    else $error("result index outside the segment run");

  a_last_param: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (t_r == crsi_pkg::T_ONE))
    else $error("final point of a run does not reach t = 1");

  a_job_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> (state_r == crsi_pkg::B_IDLE))
    else $error("back end kept running past the last point");

endmodule

>>> rtl/catmull_rom_stroke_interpolator.sv
// Top level of the Catmull-Rom stroke interpolator: front end, job queue, back end.
// Depends on crsi_pkg, crsi_front, crsi_fifo and crsi_back.
//
//  channel   dir   handshake             payload
//  in_*      in    in_tvalid/in_tready   in_tdata: control point
//  out_*     out   out_tvalid/out_tready out_tdata: point, out_tlast: end of run
//  cfg_*     in    cfg_valid/cfg_ready   cfg_data: step_precision
//
// Front end: each point from the fourth on gets a range check, then two squares and a
// step count search (one square each) unless the segment is long; it queues a job if
// the count is not zero. Back end: two serial divisions per segment, then for each
// point t^2, t^3, weights and the shared multiply-accumulate (7 fields x 4 taps).
// The two-entry job queue lets the front keep taking points while results stall.
// Reset (rst_n low, synchronous) clears the queue, counters and held-point count.
module catmull_rom_stroke_interpolator #(
  parameter int MAX_POINTS  = 64,
  parameter int COORD_WIDTH = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // x_pos, y_pos, pressure_in, xtilt_in, ytilt_in, wheel_in, velocity_in, direction_in
  input  logic [((2*COORD_WIDTH+96+7)/8)*8-1:0] in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // x_out, y_out, pressure_out, xtilt_out, ytilt_out, wheel_out, velocity_out,
  // direction_out, param_out
  output logic [((2*COORD_WIDTH+113+7)/8)*8-1:0] out_tdata,
  output logic              out_tlast,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);

  localparam int PW     = 2 * COORD_WIDTH + crsi_pkg::PT_ATTR_W;
  localparam int CNTW   = $clog2(MAX_POINTS + 1);
  localparam int JW     = 4 * PW + CNTW;
  localparam int ODW    = 2 * COORD_WIDTH + 5 * crsi_pkg::ATTR_W + 16 + crsi_pkg::T_W;
  localparam int OUT_DW = ((ODW + 7) / 8) * 8;

  logic          fj_valid, fj_ready, bj_valid, bj_ready;
  logic [JW-1:0] fj_data, bj_data;
  logic [ODW-1:0] res_data;

  crsi_front #(.MAX_POINTS(MAX_POINTS), .COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk, .rst_n,
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_point (in_tdata[PW-1:0]),
    .cfg_valid, .cfg_ready, .cfg_data,
    .job_valid(fj_valid),
    .job_ready(fj_ready),
    .job_data (fj_data)
  );

  crsi_fifo #(.DW(JW)) u_queue (
    .clk, .rst_n,
    .in_valid (fj_valid),
    .in_ready (fj_ready),
    .in_data  (fj_data),
    .out_valid(bj_valid),
    .out_ready(bj_ready),
    .out_data (bj_data)
  );

  crsi_back #(.MAX_POINTS(MAX_POINTS), .COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk, .rst_n,
    .job_valid(bj_valid),
    .job_ready(bj_ready),
    .job_data (bj_data),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (res_data),
    .out_last (out_tlast)
  );

  assign out_tdata = OUT_DW'(res_data);

endmodule

>>> verif/tb_catmull_rom_stroke_interpolator.sv
// Self-checking testbench for catmull_rom_stroke_interpolator: directed table, then
// random strokes over several step precisions, checked beat by beat against a predictor.
// Depends on rtl/crsi_pkg.sv and rtl/catmull_rom_stroke_interpolator.sv.
`timescale 1ns / 100ps

module tb_catmull_rom_stroke_interpolator;

  localparam int  CW         = 24;
  localparam int  SEG_MAX    = 64;
  localparam int  HOLD_CYC   = 3000;
  localparam int  SETTLE_CYC = 150;
  localparam longint LIMIT   = 8000000;

  // one control point, x in the low bits
  typedef struct packed {
    logic [15:0] dir, vel, wh, yt, xt, pres;
    logic [23:0] y, x;
  } pen_beat_t;

  typedef struct {
    pen_beat_t beat;
    bit        no_result;   // typed in: this row gives no segment points
  } dir_row_t;

  typedef struct { longint f[10]; } seg_point_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [167:0] out_tdata;
  logic         out_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [15:0]  cfg_data = '0;

  catmull_rom_stroke_interpolator #(.MAX_POINTS(SEG_MAX), .COORD_WIDTH(CW)) dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tlast, .cfg_valid, .cfg_ready, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint     win [4][8];
  int         pts_held;
  longint     step_prec;
  seg_point_t pending_pts[$];

  int     errors, points_sent, beats_checked, prec_settings;
  bit     no_idle, hold_req;
  longint cycles;
  string  fld_name [10] = '{"x", "y", "pressure", "xtilt", "ytilt", "wheel", "velocity",
                            "direction", "param", "last"};

  function automatic longint rshift(longint v, int k);
    return (v + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic longint fdiv(longint v, longint d);
    return (v >= 0) ? v / d : -((-v + d - 1) / d);
  endfunction

  function automatic void predict_point(pen_beat_t b, bit keep);
    longint np[8];
    longint w[4];
    longint prec, dx, dy, adx, ady, lim, s, cm, cnt, delta, t, t3, t2, t1, v, lo, hi, acc;
    seg_point_t r;
    np[0] = longint'($signed(b.x));  np[1] = longint'($signed(b.y));
    np[2] = longint'(b.pres);
    np[3] = longint'($signed(b.xt)); np[4] = longint'($signed(b.yt));
    np[5] = longint'($signed(b.wh));
    np[6] = longint'(b.vel);         np[7] = longint'(b.dir);
    for (int i = 0; i < 3; i++) win[i] = win[i+1];
    win[3] = np;
    if (pts_held < 4) pts_held++;
    if (pts_held < 4) return;
    prec = (step_prec == 0) ? 1 : step_prec;
    dx = win[2][0] - win[1][0];
    dy = win[2][1] - win[1][1];
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    lim = SEG_MAX * prec;
    if (adx >= lim || ady >= lim) begin
      cnt = SEG_MAX;
    end else begin
      s = adx * adx + ady * ady;
      cnt = 0;
      while (cnt < SEG_MAX) begin
        cm = (cnt + 1) * prec;
        if (cm * cm > s) break;
        cnt++;
      end
    end
    if (cnt == 0 || !keep) return;
    delta = win[2][7] - win[1][7];
    if (delta <= -32768) delta += 65536;
    else if (delta >= 32768) delta -= 65536;
    for (longint n = 1; n <= cnt; n++) begin
      t  = (n * 65536) / cnt;
      t3 = t * t * t;
      t2 = (t * t) * 65536;
      t1 = t << 32;
      w[0] = rshift(-t3 + 2 * t2 - t1, 19);
      w[1] = rshift(3 * t3 - 5 * t2 + (longint'(1) << 49), 19);
      w[2] = rshift(-3 * t3 + 4 * t2 + t1, 19);
      w[3] = rshift(t3 - t2, 19);
      for (int k = 0; k < 7; k++) begin
        acc = 0;
        for (int j = 0; j < 4; j++) acc += w[j] * win[j][k];
        v = rshift(acc, 30);
        if (k < 2) begin
          lo = -(longint'(1) << (CW - 1)); hi = (longint'(1) << (CW - 1)) - 1;
        end else if (k == 2 || k == 6) begin
          lo = 0; hi = 32768;
        end else begin
          lo = -32768; hi = 32767;
        end
        v = v < lo ? lo : (v > hi ? hi : v);
        r.f[k] = v & ((k < 2) ? 64'hFFFFFF : 64'hFFFF);
      end
      r.f[7] = (win[1][7] + fdiv(delta * n, cnt)) & 64'hFFFF;
      r.f[8] = t & 64'h1FFFF;
      r.f[9] = longint'(n == cnt);
      pending_pts.push_back(r);
    end
  endfunction

  function automatic pen_beat_t mk(int x, int y, int p, int xt, int yt, int wh, int v, int d);
    pen_beat_t b;
    b.x = 24'(x); b.y = 24'(y); b.pres = 16'(p); b.xt = 16'(xt); b.yt = 16'(yt);
    b.wh = 16'(wh); b.vel = 16'(v); b.dir = 16'(d);
    return b;
  endfunction

  // sender: one beat per call, random gaps unless no_idle
  task automatic send_point(pen_beat_t b, bit typed_none);
    if (!no_idle) begin
      while ($urandom_range(99) < 27) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    predict_point(b, !typed_none);
    points_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending_pts.size() == 0);
  endtask

  task automatic write_precision(logic [15:0] val);
    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);   // zero-count points may still be in the front end
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    step_prec = longint'(val);
    prec_settings++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  int cur_x, cur_y;

  task automatic random_stroke(int count);
    int scale, r, dx, dy;
    pen_beat_t b;
    scale = (step_prec == 0) ? 1 : int'(step_prec);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        b = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};   // raw noise
      end else begin
        if (r < 12) begin
          dx = $urandom; dy = $urandom;                             // long jump
        end else begin
          dx = $urandom_range(12 * scale) - 6 * scale;
          dy = $urandom_range(12 * scale) - 6 * scale;
        end
        cur_x += dx; cur_y += dy;
        b = mk(cur_x, cur_y, $urandom_range(32768), $urandom, $urandom, $urandom,
               $urandom_range(32768), $urandom);
      end
      send_point(b, 1'b0);
    end
  endtask

  // receiver
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYC) @(negedge clk);
      end else begin
        out_tready <= no_idle || ($urandom_range(99) >= 27);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    seg_point_t e;
    longint a[10];
    if (rst_n && out_tvalid && out_tready) begin
      a[0] = longint'(out_tdata[23:0]);    a[1] = longint'(out_tdata[47:24]);
      a[2] = longint'(out_tdata[63:48]);   a[3] = longint'(out_tdata[79:64]);
      a[4] = longint'(out_tdata[95:80]);   a[5] = longint'(out_tdata[111:96]);
      a[6] = longint'(out_tdata[127:112]); a[7] = longint'(out_tdata[143:128]);
      a[8] = longint'(out_tdata[160:144]); a[9] = longint'(out_tlast);
      if (pending_pts.size() == 0) begin
        $display("%0t: unexpected result beat, data %h last %b", $time, out_tdata, out_tlast);
        errors++;
      end else begin
        e = pending_pts.pop_front();
        for (int k = 0; k < 10; k++)
          if (e.f[k] != a[k]) begin
            $display("%0t: %s expected %0h actual %0h", $time, fld_name[k], e.f[k], a[k]);
            errors++;
          end
        beats_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles, pending_pts.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  dir_row_t dir_tbl[$];

  initial begin
    pts_held = 0;
    step_prec = longint'(crsi_pkg::PREC_RESET);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fewer than four held, then a zero-length and a sub-step segment
    dir_tbl.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0), 1});
    dir_tbl.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0), 1});
    dir_tbl.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0), 1});
    dir_tbl.push_back('{mk(100, 50, 16384, 100, -100, 5, 200, 300), 1});
    dir_tbl.push_back('{mk(8388607, -8388608, 32768, -32768, 32767, -32768, 32768, 65535), 1});
    // field extremes, saturating long segments and both direction wraps
    dir_tbl.push_back('{mk(-8388608, 8388607, 0, 32767, -32768, 32767, 0, 0), 0});
    dir_tbl.push_back('{mk(8388607, -8388608, 65535, -32768, 32767, -32768, 65535, 32768), 0});
    dir_tbl.push_back('{mk(0, 0, 32768, 0, 0, 0, 32768, 0), 0});
    dir_tbl.push_back('{mk(768, 0, 0, 1000, -1000, 0, 0, 32768), 0});
    dir_tbl.push_back('{mk(1023, 300, 20000, -5, 5, 77, 1000, 32767), 0});
    dir_tbl.push_back('{mk(2000, -400, 100, 32767, -32768, -1, 30000, 1), 0});
    dir_tbl.push_back('{mk(-2000, 4000, 65535, -1, 1, 32767, 65535, 65534), 0});
    dir_tbl.push_back('{mk(-1, -1, 1, 2, 3, 4, 5, 6), 0});
    dir_tbl.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0), 0});
    foreach (dir_tbl[i]) send_point(dir_tbl[i].beat, dir_tbl[i].no_result);
    cur_x = 0; cur_y = 0;
    random_stroke(60);

    write_precision(16'd1);
    hold_req = 1'b1;                    // long receiver stall with points still offered
    random_stroke(70);

    write_precision(16'd65535);
    random_stroke(30);
    wait_drained();                     // sender pause until everything is back
    random_stroke(30);

    write_precision(16'd0);
    no_idle = 1'b1;
    random_stroke(60);
    no_idle = 1'b0;

    write_precision(16'($urandom_range(65535, 1)));
    random_stroke(60);

    write_precision(16'd16);
    random_stroke(70);

    write_precision(crsi_pkg::PREC_RESET);
    random_stroke(60);

    wait_drained();
    repeat (200) @(posedge clk);
    $display("sent %0d pen points, checked %0d interpolated beats over %0d precision settings",
             points_sent, beats_checked, prec_settings + 1);
    $display("covered window fill, zero and saturated step counts, wraps, stalls and noise");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
